// ===== rtl/core/sensor_response_crc_checker_top_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the sensor response CRC checker
// Clocked on clk with reset rst_n; empty when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef SENSOR_RESPONSE_CRC_CHECKER_TOP_MACROS_SVH
`define SENSOR_RESPONSE_CRC_CHECKER_TOP_MACROS_SVH

`ifndef SYNTH

// Condition that must hold at every clock edge out of reset
`define SRCC_ASSERT(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("srcc assertion failed");

// Implication checked in the same cycle
`define SRCC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("srcc implication failed");

// Implication checked in the next cycle
`define SRCC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srcc next-cycle implication failed");

`else

`define SRCC_ASSERT(label, expr)
`define SRCC_ASSERT_IMP(label, ante, cons)
`define SRCC_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== rtl/core/srcc_pkg.sv =====
// ---------------------------------------------------------------------------
// srcc_pkg
// Shared types and constants of the sensor response CRC checker.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package srcc_pkg;

    localparam logic [7:0] CRC_POLY       = 8'h31;
    localparam logic [7:0] CRC_SEED_RST   = 8'hFF;
    localparam logic [3:0] FAIL_LIMIT_RST = 4'd5;
    localparam logic [3:0] FAIL_CNT_MAX   = 4'hF;

    // Byte positions within a six-byte reply
    localparam logic [2:0] POS_CO2_HI  = 3'd0;
    localparam logic [2:0] POS_CO2_LO  = 3'd1;
    localparam logic [2:0] POS_CO2_CRC = 3'd2;
    localparam logic [2:0] POS_TVOC_HI = 3'd3;
    localparam logic [2:0] POS_TVOC_LO = 3'd4;
    localparam logic [2:0] POS_TVOC_CRC = 3'd5;

    // Configuration register indexes
    localparam logic CFG_CRC_SEED   = 1'b0;
    localparam logic CFG_FAIL_LIMIT = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_CO2_CRC  = 2'd1,
        ST_TVOC_CRC = 2'd2,
        ST_CO2_ZERO = 2'd3
    } status_t;

    // Result item, packed with co2_value in the lowest bits
    typedef struct packed {
        logic        reinit_request;
        logic [3:0]  failure_count;
        status_t     status_code;
        logic        values_valid;
        logic [15:0] tvoc_value;
        logic [15:0] co2_value;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/srcc_crc8.sv =====
// ---------------------------------------------------------------------------
// srcc_crc8
// One-byte CRC-8 update, MSB first, polynomial from the package.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srcc_crc8 (
    input  wire logic [7:0] rem,
    input  wire logic [7:0] data,
    output logic      [7:0] crc
);

    always_comb
    begin
        logic [7:0] r;
        r = rem ^ data;
        for (int k = 0; k < 8; k++)
        begin
            if (r[7])
            begin
                r = {r[6:0], 1'b0} ^ srcc_pkg::CRC_POLY;
            end
            else
            begin
                r = {r[6:0], 1'b0};
            end
        end
        crc = r;
    end

endmodule

`default_nettype wire

// ===== rtl/core/sensor_response_crc_checker_top.sv =====
// ---------------------------------------------------------------------------
// sensor_response_crc_checker_top
// Checks a gas sensor's six-byte measurement reply and reports the words.
// ---------------------------------------------------------------------------
// Usage:
//   Input stream s_*: one reply byte per item in s_tdata, s_tuser set on the
//   first byte of a reply to resynchronize the byte position. Bytes come in
//   bus order: CO2 high, CO2 low, CO2 CRC, TVOC high, TVOC low, TVOC CRC.
//   Output stream m_*: one result item per completed reply, carrying both
//   words, a valid flag, status, failure count and a reinit request.
//   Config channel cfg_*: index 0 writes the CRC seed, index 1 the failure
//   limit (low four bits of cfg_data); always ready, write only when idle.
// Timing:
//   One byte accepted per cycle while no result is held up on m_*. The byte lands
//   in an input register, the CRC update and reply check run combinationally
//   on it, and the result lands in the output register, from which the result
//   item is presented on m_*.
// Reset and stall:
//   Reset clears the byte position, the failure counter and both valid flags
//   and loads the register defaults (seed 0xFF, limit 5). When the receiver
//   holds m_tready low with a result waiting, the input register still
//   takes bytes that produce no result; it stalls only on the next sixth byte.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "sensor_response_crc_checker_top_macros.svh"

module sensor_response_crc_checker_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  wire logic        s_tuser,   // [0] frame_start
    // output stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [15:0] co2_value, [31:16] tvoc_value, [32] values_valid,
    // [34:33] status_code, [38:35] failure_count, [39] reinit_request
    output logic      [39:0] m_tdata,
    // configuration
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [7:0]  cfg_data
);

    // configuration registers
    logic [7:0] crc_seed_reg;
    logic [3:0] fail_limit_reg;

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_start_reg;

    // reply state
    logic [2:0]  byte_pos_reg,   byte_pos_next;
    logic [7:0]  crc_reg,        crc_next;
    logic [7:0]  high_byte_reg,  high_byte_next;
    logic [15:0] co2_word_reg,   co2_word_next;
    logic [15:0] tvoc_word_reg,  tvoc_word_next;
    logic        co2_bad_reg,    co2_bad_next;
    logic [3:0]  fail_cnt_reg,   fail_cnt_next;

    // output register
    logic                    out_valid_reg;
    srcc_pkg::result_t       out_data_reg;
    srcc_pkg::result_t       result;

    logic [2:0] pos;
    logic [7:0] crc_rem;
    logic [7:0] crc_out;
    logic       emit;
    logic       advance;
    logic       fire;
    logic [3:0] cnt_bumped;
    logic       tvoc_bad;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_seed_reg   <= srcc_pkg::CRC_SEED_RST;
            fail_limit_reg <= srcc_pkg::FAIL_LIMIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                srcc_pkg::CFG_CRC_SEED:   crc_seed_reg   <= cfg_data;
                srcc_pkg::CFG_FAIL_LIMIT: fail_limit_reg <= cfg_data[3:0];
                default:                  ;
            endcase
        end
    end

    // Effective byte position; frame start and stray positions restart the reply
    always_comb
    begin
        if (in_start_reg || (byte_pos_reg > srcc_pkg::POS_TVOC_CRC))
        begin
            pos = srcc_pkg::POS_CO2_HI;
        end
        else
        begin
            pos = byte_pos_reg;
        end
    end

    assign crc_rem = ((pos == srcc_pkg::POS_CO2_HI) || (pos == srcc_pkg::POS_TVOC_HI))
                   ? crc_seed_reg : crc_reg;

    srcc_crc8 u_crc8 (
        .rem  (crc_rem),
        .data (in_byte_reg),
        .crc  (crc_out)
    );

    assign emit     = in_valid_reg && (pos == srcc_pkg::POS_TVOC_CRC);
    assign advance  = !emit || !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    // Reply check on the sixth byte
    always_comb
    begin
        tvoc_bad = (crc_reg != in_byte_reg);
        result   = '0;
        if (co2_bad_reg)
        begin
            result.status_code = srcc_pkg::ST_CO2_CRC;
        end
        else if (tvoc_bad)
        begin
            result.status_code = srcc_pkg::ST_TVOC_CRC;
        end
        else
        begin
            result.values_valid = 1'b1;
            result.co2_value    = co2_word_reg;
            result.tvoc_value   = tvoc_word_reg;
            result.status_code  = (co2_word_reg[15:8] == 8'h00)
                                ? srcc_pkg::ST_CO2_ZERO : srcc_pkg::ST_OK;
        end

        if (result.status_code == srcc_pkg::ST_OK)
        begin
            cnt_bumped = '0;
        end
        else if (fail_cnt_reg == srcc_pkg::FAIL_CNT_MAX)
        begin
            cnt_bumped = fail_cnt_reg;
        end
        else
        begin
            cnt_bumped = fail_cnt_reg + 4'd1;
        end
        result.failure_count  = cnt_bumped;
        result.reinit_request = (cnt_bumped > fail_limit_reg);
    end

    always_comb
    begin
        byte_pos_next  = byte_pos_reg;
        crc_next       = crc_reg;
        high_byte_next = high_byte_reg;
        co2_word_next  = co2_word_reg;
        tvoc_word_next = tvoc_word_reg;
        co2_bad_next   = co2_bad_reg;
        fail_cnt_next  = fail_cnt_reg;
        if (fire)
        begin
            unique case (pos) inside
                srcc_pkg::POS_CO2_HI, srcc_pkg::POS_TVOC_HI:
                begin
                    high_byte_next = in_byte_reg;
                    crc_next       = crc_out;
                    byte_pos_next  = pos + 3'd1;
                end
                srcc_pkg::POS_CO2_LO:
                begin
                    crc_next      = crc_out;
                    co2_word_next = {high_byte_reg, in_byte_reg};
                    byte_pos_next = srcc_pkg::POS_CO2_CRC;
                end
                srcc_pkg::POS_CO2_CRC:
                begin
                    co2_bad_next  = (crc_reg != in_byte_reg);
                    byte_pos_next = srcc_pkg::POS_TVOC_HI;
                end
                srcc_pkg::POS_TVOC_LO:
                begin
                    crc_next       = crc_out;
                    tvoc_word_next = {high_byte_reg, in_byte_reg};
                    byte_pos_next  = srcc_pkg::POS_TVOC_CRC;
                end
                default:
                begin
                    byte_pos_next = srcc_pkg::POS_CO2_HI;
                    fail_cnt_next = result.reinit_request ? 4'd0 : result.failure_count;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            byte_pos_reg  <= srcc_pkg::POS_CO2_HI;
            fail_cnt_reg  <= '0;
            co2_bad_reg   <= 1'b0;
            crc_reg       <= srcc_pkg::CRC_SEED_RST;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (emit && advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            byte_pos_reg <= byte_pos_next;
            fail_cnt_reg <= fail_cnt_next;
            co2_bad_reg  <= co2_bad_next;
            crc_reg      <= crc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg  <= s_tdata;
            in_start_reg <= s_tuser;
        end
        if (emit && advance)
        begin
            out_data_reg <= result;
        end
        high_byte_reg <= high_byte_next;
        co2_word_reg  <= co2_word_next;
        tvoc_word_reg <= tvoc_word_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    `SRCC_ASSERT(a_pos_in_range, byte_pos_reg <= srcc_pkg::POS_TVOC_CRC)
    `SRCC_ASSERT_IMP(a_invalid_zero, out_valid_reg && !out_data_reg.values_valid,
        (out_data_reg.co2_value == 16'h0) && (out_data_reg.tvoc_value == 16'h0))
    `SRCC_ASSERT_IMP(a_ok_is_valid,
        out_valid_reg && (out_data_reg.status_code == srcc_pkg::ST_OK),
        out_data_reg.values_valid)
    `SRCC_ASSERT_NEXT(a_reinit_clears, emit && advance && result.reinit_request,
        fail_cnt_reg == 4'd0)

endmodule

`default_nettype wire

// ===== bench/sensor_response_crc_checker_top_test.sv =====
// ---------------------------------------------------------------------------
// sensor_response_crc_checker_top_test
// Self-checking bench for the sensor reply CRC checker. Reply bytes go in on
// the input stream. A scoreboard tracks byte position, CRC and the failure
// counter, and predicts each reply's reading. Readings from the output stream
// are compared field by field. Runs cover several seed and limit settings,
// random idle on both streams, and one long receiver hold-off.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sensor_response_crc_checker_top_test;

    localparam int CYCLE_LIMIT = 300000;
    localparam int PHASE_BYTES = 200;

    class reply_scoreboard;
        logic [7:0]  seed_reg;
        logic [3:0]  limit_reg;
        logic [2:0]  position;
        logic [7:0]  crc_run;
        logic [7:0]  high_byte;
        logic [15:0] co2_word;
        logic [15:0] tvoc_word;
        logic        co2_bad;
        logic [3:0]  fail_count;
        srcc_pkg::result_t pending_readings[$];
        int          readings_seen;
        int          errors;

        function new();
            seed_reg      = srcc_pkg::CRC_SEED_RST;
            limit_reg     = srcc_pkg::FAIL_LIMIT_RST;
            position      = srcc_pkg::POS_CO2_HI;
            crc_run       = srcc_pkg::CRC_SEED_RST;
            high_byte     = '0;
            co2_word      = '0;
            tvoc_word     = '0;
            co2_bad       = 1'b0;
            fail_count    = '0;
            readings_seen = 0;
            errors        = 0;
        endfunction

        function logic [7:0] crc_step(logic [7:0] rem, logic [7:0] b);
            logic [7:0] r;
            r = rem ^ b;
            for (int k = 0; k < 8; k++)
            begin
                r = r[7] ? ((r << 1) ^ srcc_pkg::CRC_POLY) : (r << 1);
            end
            return r;
        endfunction

        function void set_reg(logic idx, logic [7:0] value);
            if (idx == srcc_pkg::CFG_CRC_SEED)
                seed_reg = value;
            else
                limit_reg = value[3:0];
        endfunction

        function int pending();
            return pending_readings.size();
        endfunction

        // Advance the reply state by one accepted byte.
        function void take_byte(logic [7:0] b, logic frame_start);
            logic [2:0]        at;
            srcc_pkg::status_t st;
            logic              good;
            srcc_pkg::result_t r;
            at = frame_start ? srcc_pkg::POS_CO2_HI : position;
            if (at > srcc_pkg::POS_TVOC_CRC)
                at = srcc_pkg::POS_CO2_HI;
            case (at)
                srcc_pkg::POS_CO2_HI, srcc_pkg::POS_TVOC_HI:
                begin
                    high_byte = b;
                    crc_run   = crc_step(seed_reg, b);
                    position  = at + 3'd1;
                end
                srcc_pkg::POS_CO2_LO:
                begin
                    crc_run  = crc_step(crc_run, b);
                    co2_word = {high_byte, b};
                    position = srcc_pkg::POS_CO2_CRC;
                end
                srcc_pkg::POS_CO2_CRC:
                begin
                    co2_bad  = (crc_run != b);
                    position = srcc_pkg::POS_TVOC_HI;
                end
                srcc_pkg::POS_TVOC_LO:
                begin
                    crc_run   = crc_step(crc_run, b);
                    tvoc_word = {high_byte, b};
                    position  = srcc_pkg::POS_TVOC_CRC;
                end
                default:
                begin
                    position = srcc_pkg::POS_CO2_HI;
                    good     = 1'b0;
                    if (co2_bad)
                        st = srcc_pkg::ST_CO2_CRC;
                    else if (crc_run != b)
                        st = srcc_pkg::ST_TVOC_CRC;
                    else
                    begin
                        good = 1'b1;
                        st   = (co2_word[15:8] == 8'd0) ? srcc_pkg::ST_CO2_ZERO
                                                        : srcc_pkg::ST_OK;
                    end
                    if (st == srcc_pkg::ST_OK)
                        fail_count = '0;
                    else if (fail_count != srcc_pkg::FAIL_CNT_MAX)
                        fail_count = fail_count + 4'd1;
                    r.co2_value      = good ? co2_word : 16'd0;
                    r.tvoc_value     = good ? tvoc_word : 16'd0;
                    r.values_valid   = good;
                    r.status_code    = st;
                    r.failure_count  = fail_count;
                    r.reinit_request = (fail_count > limit_reg);
                    if (fail_count > limit_reg)
                        fail_count = '0;
                    pending_readings.push_back(r);
                end
            endcase
        endfunction

        task report(string what);
            errors++;
            $display("mismatch: reading %0d %s", readings_seen, what);
        endtask

        task check_reading(logic [39:0] data);
            srcc_pkg::result_t got;
            srcc_pkg::result_t want;
            got = data;
            readings_seen++;
            if (pending_readings.size() == 0)
            begin
                report($sformatf("unexpected item %h", data));
                return;
            end
            want = pending_readings.pop_front();
            if (got.co2_value !== want.co2_value)
                report($sformatf("co2_value %h, want %h", got.co2_value, want.co2_value));
            if (got.tvoc_value !== want.tvoc_value)
                report($sformatf("tvoc_value %h, want %h", got.tvoc_value, want.tvoc_value));
            if (got.values_valid !== want.values_valid)
                report($sformatf("values_valid %b, want %b",
                                 got.values_valid, want.values_valid));
            if (got.status_code !== want.status_code)
                report($sformatf("status_code %0d, want %0d",
                                 got.status_code, want.status_code));
            if (got.failure_count !== want.failure_count)
                report($sformatf("failure_count %0d, want %0d",
                                 got.failure_count, want.failure_count));
            if (got.reinit_request !== want.reinit_request)
                report($sformatf("reinit_request %b, want %b",
                                 got.reinit_request, want.reinit_request));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [7:0]  cfg_data;

    reply_scoreboard sb;
    int bytes_sent;
    int cycle_count;
    int long_hold;
    int ready_hold;
    bit quiet;

    sensor_response_crc_checker_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one.
    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Receiver: check readings, stall at random, honor a requested hold-off.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_reading(m_tdata);
            if (long_hold > 0)
            begin
                ready_hold = long_hold;
                long_hold  = 0;
            end
            if (ready_hold > 0)
            begin
                m_tready <= 1'b0;
                ready_hold--;
            end
            else
            begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 99) < 30)
                    ready_hold = pick_gap();
            end
        end
    end

    task send_byte(input logic [7:0] b, input logic frame_start);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= frame_start;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.take_byte(b, frame_start);
        bytes_sent++;
    endtask

    // Send the first keep bytes of a reply; flips corrupt the CRC bytes.
    task send_words(input logic [15:0] co2w, input logic [15:0] tvocw,
                    input logic [7:0] co2_flip, input logic [7:0] tvoc_flip,
                    input logic lead, input int keep);
        logic [7:0] bytes [6];
        bytes[0] = co2w[15:8];
        bytes[1] = co2w[7:0];
        bytes[2] = sb.crc_step(sb.crc_step(sb.seed_reg, co2w[15:8]), co2w[7:0]) ^ co2_flip;
        bytes[3] = tvocw[15:8];
        bytes[4] = tvocw[7:0];
        bytes[5] = sb.crc_step(sb.crc_step(sb.seed_reg, tvocw[15:8]), tvocw[7:0])
                   ^ tvoc_flip;
        for (int i = 0; i < keep; i++)
            send_byte(bytes[i], (i == 0) ? lead : 1'b0);
    endtask

    task write_reg(input logic idx, input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_reg(idx, value);
    endtask

    task configure(input logic [7:0] seed, input logic [7:0] limit_data);
        write_reg(srcc_pkg::CFG_CRC_SEED, seed);
        write_reg(srcc_pkg::CFG_FAIL_LIMIT, limit_data);
        cfg_valid <= 1'b0;
    endtask

    // Stop sending, wait for every reading, then let the pipeline empty.
    task settle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task run_phase(input int good_pct);
        int         first;
        int         r;
        int         n;
        bit         need_start;
        logic [15:0] co2w;
        logic [7:0] co2_flip;
        logic [7:0] tvoc_flip;
        first      = bytes_sent;
        need_start = 1'b1;
        while (bytes_sent - first < PHASE_BYTES)
        begin
            r    = $urandom_range(0, 99);
            co2w = 16'($urandom_range(0, 16'hFFFF));
            if ($urandom_range(0, 9) == 0)
                co2w[15:8] = 8'd0;
            co2_flip  = ($urandom_range(0, 99) < good_pct) ? 8'd0
                                                           : 8'($urandom_range(1, 255));
            tvoc_flip = ($urandom_range(0, 99) < good_pct) ? 8'd0
                                                           : 8'($urandom_range(1, 255));
            if (r < 80)
            begin
                send_words(co2w, 16'($urandom_range(0, 16'hFFFF)), co2_flip, tvoc_flip,
                           need_start || ($urandom_range(0, 4) != 0), 6);
                need_start = 1'b0;
            end
            else if (r < 90)
            begin
                send_words(co2w, 16'($urandom_range(0, 16'hFFFF)), co2_flip, tvoc_flip,
                           1'b1, $urandom_range(1, 5));
                need_start = 1'b1;
            end
            else
            begin
                n = $urandom_range(1, 3);
                repeat (n)
                    send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
                need_start = 1'b1;
            end
        end
    endtask

    initial
    begin
        logic [7:0] seed;
        logic [7:0] limit_data;
        int         good;
        clk         = 1'b0;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = 1'b0;
        m_tready    = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = srcc_pkg::CFG_CRC_SEED;
        cfg_data    = '0;
        bytes_sent  = 0;
        cycle_count = 0;
        long_hold   = 0;
        ready_hold  = 0;
        quiet       = 1'b0;
        sb          = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed replies on reset defaults.
        send_words(16'hFFFF, 16'h0000, 8'h00, 8'h00, 1'b1, 6);
        // zero CO2 high byte, position carried over without frame start
        send_words(16'h00FF, 16'hFFFF, 8'h00, 8'h00, 1'b0, 6);
        // partial reply, dropped by the next frame start
        send_words(16'h1234, 16'h5678, 8'h00, 8'h00, 1'b1, 2);
        send_words(16'h8001, 16'h7FFE, 8'h01, 8'h00, 1'b1, 6);
        send_words(16'hA55A, 16'h0F0F, 8'h00, 8'h80, 1'b1, 6);
        settle();

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0:
                begin
                    seed = 8'h00; limit_data = 8'h00; good = 70;
                end
                1:
                begin
                    seed = 8'hFF; limit_data = 8'h0E; good = 5;
                end
                2:
                begin
                    seed = 8'($urandom_range(0, 255)); limit_data = 8'hFF; good = 5;
                end
                3:
                begin
                    seed = 8'hA5; limit_data = 8'hF3; good = 80;
                end
                default:
                begin
                    seed = 8'($urandom_range(0, 255));
                    limit_data = 8'($urandom_range(0, 255));
                    good = 75;
                end
            endcase
            quiet = (ph == 3);
            configure(seed, limit_data);
            // hold the receiver off while the sender keeps pushing bytes
            if (ph == 3)
                long_hold = 300;
            run_phase(good);
            settle();
        end

        repeat (10) @(posedge clk);
        if (sb.errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
